// ----- rtl/sensor_frame_repacker_defines.svh -----
// Assertion helpers for the checker file of the frame repacker.
`ifndef SENSOR_FRAME_REPACKER_DEFINES_SVH
`define SENSOR_FRAME_REPACKER_DEFINES_SVH

// Concurrent assertion on a given clock, off while the reset is high.
`define SRP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, on the block's own clock and reset names.
`define SRP_ASSERT_CLK(lbl, prop, msg) `SRP_ASSERT(lbl, clock, reset, prop, msg)

`endif

// ----- rtl/srp_pkg.sv -----
// ---------------------------------------------------------------------------
// srp_pkg
// Constants, types and helpers for the sensor frame repacker.
// ---------------------------------------------------------------------------
package srp_pkg;

   localparam int CAPTURE_DEPTH = 50;
   localparam int CAP_AW        = $clog2(CAPTURE_DEPTH);
   localparam int CNT_W         = $clog2(CAPTURE_DEPTH + 1);

   localparam int FRAME_LEN     = 44;
   localparam int HDR_LEN       = 10;
   localparam int PAYLOAD_LEN   = 34;
   localparam int TRIGGER_COUNT = 43;
   localparam int PAY_AW        = $clog2(PAYLOAD_LEN);
   localparam int IDX_W         = $clog2(FRAME_LEN);

   localparam int BYTE_W = 8;
   localparam int CSR_AW = 4;

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h5A;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hA5;
   localparam logic [BYTE_W-1:0] FRAME_TAG   = 8'hD1;
   localparam logic [BYTE_W-1:0] CHAR_HASH   = 8'h23;
   localparam logic [BYTE_W-1:0] CHAR_ONE    = 8'h01;
   localparam logic [BYTE_W-1:0] CHAR_D      = 8'h44;

   // Capture positions checked before a frame goes out
   localparam logic [CAP_AW-1:0] CHECK_HEAD_POS = CAP_AW'(0);
   localparam logic [CAP_AW-1:0] CHECK_TAG_POS  = CAP_AW'(26);

   // Frame header positions
   localparam logic [IDX_W-1:0] HDR_HASH0  = IDX_W'(0);
   localparam logic [IDX_W-1:0] HDR_ONE    = IDX_W'(1);
   localparam logic [IDX_W-1:0] HDR_HASH1  = IDX_W'(2);
   localparam logic [IDX_W-1:0] HDR_D      = IDX_W'(3);
   localparam logic [IDX_W-1:0] HDR_STATUS = IDX_W'(4);
   localparam logic [IDX_W-1:0] HDR_NODE   = IDX_W'(5);

   typedef enum logic [CSR_AW-1:0] {
      CSR_NODE_ID        = 4'd0,
      CSR_FORWARD_ENABLE = 4'd1,
      CSR_VALID_CODE     = 4'd2,
      CSR_INVALID_CODE   = 4'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK_HEAD,
      ST_CHECK_TAG,
      ST_CHECK_EVAL,
      ST_FETCH,
      ST_EMIT
   } state_type;

   // Capture position of payload byte k: start at 6, skip one byte after each of the first three runs of six
   function automatic logic [CAP_AW-1:0] payload_addr(input logic [PAY_AW-1:0] k);
      logic [CAP_AW-1:0] kk;
      kk = CAP_AW'(k);
      if (k < PAY_AW'(6)) begin
         return kk + CAP_AW'(6);
      end else if (k < PAY_AW'(12)) begin
         return kk + CAP_AW'(7);
      end else if (k < PAY_AW'(18)) begin
         return kk + CAP_AW'(8);
      end else begin
         return kk + CAP_AW'(9);
      end
   endfunction

endpackage

// ----- rtl/srp_if.sv -----
// ---------------------------------------------------------------------------
// srp_req_if / srp_rsp_if / srp_csr_if
// Valid/ready channels of the sensor frame repacker.
// ---------------------------------------------------------------------------
interface srp_req_if;
   import srp_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface srp_rsp_if;
   import srp_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] tx_byte;
   logic              frame_end;
   modport source (output valid, output tx_byte, output frame_end, input ready);
   modport sink   (input valid, input tx_byte, input frame_end, output ready);
endinterface

interface srp_csr_if;
   import srp_pkg::*;
   logic              valid;
   logic              ready;
   logic [CSR_AW-1:0] index;
   logic [BYTE_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/srp_ram.sv -----
// ---------------------------------------------------------------------------
// srp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module srp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sensor_frame_repacker.sv -----
// ---------------------------------------------------------------------------
// sensor_frame_repacker
// Captures sensor bytes and repacks the first 43 of each capture into a 44-byte frame.
// ---------------------------------------------------------------------------
// Use: sensor bytes arrive one per request on req_chan. A 0x5A, 0xA5 pair
// restarts capture at position 0. Frame bytes leave on rsp_chan, frame_end
// marking the 44th. Registers are written through csr_chan, which is always
// ready; write them only while no frame is in flight.
// Throughput: bytes that start no frame are taken one per cycle, so they
// may stream back to back. The byte that completes the 43rd capture
// position (with forwarding on) holds req_chan.ready low through the check
// states (head, tag, eval) and a fetch and an emit state per frame byte,
// the emit state waiting while the receiver stalls; each payload byte is
// read on the capture RAM's single read port, through one shared output register.
// The first frame byte is registered out after the check, fetch and emit states.
// Stall: while rsp_chan.ready is low the output register holds its byte and
// the sequencer waits; the last byte may wait while new requests are taken.
// Reset: synchronous; clears the fill count, last byte, held-payload mark and
// registers (valid code to 0x01); an invalid frame before a valid one sends zero payload.
// ---------------------------------------------------------------------------
module sensor_frame_repacker (
   input  logic      clock,
   input  logic      reset,
   srp_req_if.sink   req_chan,
   srp_rsp_if.source rsp_chan,
   srp_csr_if.sink   csr_chan
);
   import srp_pkg::*;

   state_type state_ff, state_in;

   logic [BYTE_W-1:0] node_id_ff, node_id_in;
   logic              fwd_en_ff, fwd_en_in;
   logic [BYTE_W-1:0] valid_code_ff, valid_code_in;
   logic [BYTE_W-1:0] invalid_code_ff, invalid_code_in;

   logic [BYTE_W-1:0] prev_ff, prev_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              head_ok_ff, head_ok_in;
   logic              ok_ff, ok_in;
   logic              held_valid_ff, held_valid_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_end_ff, rsp_end_in;

   logic              req_fire, restart, store, trigger, out_free, in_payload;
   logic [CNT_W-1:0]  count_base, count_inc;
   logic [PAY_AW-1:0] pay_idx;
   logic [BYTE_W-1:0] hdr_byte, pay_byte;

   logic              cap_wr_en, cap_rd_en, held_wr_en, held_rd_en;
   logic [CAP_AW-1:0] cap_wr_addr, cap_rd_addr;
   logic [BYTE_W-1:0] cap_rd_data, held_rd_data;

   srp_ram #(.WIDTH(BYTE_W), .DEPTH(CAPTURE_DEPTH)) u_capture_ram (
      .clock   (clock),
      .wr_en   (cap_wr_en),
      .wr_addr (cap_wr_addr),
      .wr_data (req_chan.rx_byte),
      .rd_en   (cap_rd_en),
      .rd_addr (cap_rd_addr),
      .rd_data (cap_rd_data)
   );

   srp_ram #(.WIDTH(BYTE_W), .DEPTH(PAYLOAD_LEN)) u_held_ram (
      .clock   (clock),
      .wr_en   (held_wr_en),
      .wr_addr (pay_idx),
      .wr_data (cap_rd_data),
      .rd_en   (held_rd_en),
      .rd_addr (pay_idx),
      .rd_data (held_rd_data)
   );

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.tx_byte   = rsp_byte_ff;
   assign rsp_chan.frame_end = rsp_end_ff;
   assign csr_chan.ready     = 1'b1;

   assign req_fire   = req_chan.valid && (state_ff == ST_IDLE);
   assign restart    = (prev_ff == SYNC_FIRST) && (req_chan.rx_byte == SYNC_SECOND);
   assign count_base = restart ? '0 : fill_ff;
   assign store      = (count_base < CNT_W'(CAPTURE_DEPTH));
   assign count_inc  = count_base + CNT_W'(1);
   assign trigger    = store && (count_inc == CNT_W'(TRIGGER_COUNT)) && fwd_en_ff;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign in_payload = (idx_ff >= IDX_W'(HDR_LEN));
   assign pay_idx    = PAY_AW'(idx_ff - IDX_W'(HDR_LEN));

   // Header byte for the current frame position; reserved bytes send zero
   always_comb begin
      case (idx_ff)
         HDR_HASH0:  hdr_byte = CHAR_HASH;
         HDR_ONE:    hdr_byte = CHAR_ONE;
         HDR_HASH1:  hdr_byte = CHAR_HASH;
         HDR_D:      hdr_byte = CHAR_D;
         HDR_STATUS: hdr_byte = ok_ff ? valid_code_ff : invalid_code_ff;
         HDR_NODE:   hdr_byte = node_id_ff;
         default:    hdr_byte = '0;
      endcase
   end

   // A valid frame sends fresh capture bytes; otherwise the held copy, or zero before any is held
   assign pay_byte = ok_ff ? cap_rd_data : (held_valid_ff ? held_rd_data : '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && trigger) begin
               state_in = ST_CHECK_HEAD;
            end
         end
         ST_CHECK_HEAD: state_in = ST_CHECK_TAG;
         ST_CHECK_TAG:  state_in = ST_CHECK_EVAL;
         ST_CHECK_EVAL: state_in = ST_FETCH;
         ST_FETCH:      state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = (idx_ff == IDX_W'(FRAME_LEN - 1)) ? ST_IDLE : ST_FETCH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      node_id_in      = node_id_ff;
      fwd_en_in       = fwd_en_ff;
      valid_code_in   = valid_code_ff;
      invalid_code_in = invalid_code_ff;
      prev_in         = prev_ff;
      fill_in         = fill_ff;
      head_ok_in      = head_ok_ff;
      ok_in           = ok_ff;
      held_valid_in   = held_valid_ff;
      idx_in          = idx_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in     = rsp_byte_ff;
      rsp_end_in      = rsp_end_ff;
      cap_wr_en       = 1'b0;
      cap_wr_addr     = count_base[CAP_AW-1:0];
      cap_rd_en       = 1'b0;
      cap_rd_addr     = CHECK_HEAD_POS;
      held_wr_en      = 1'b0;
      held_rd_en      = 1'b0;

      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_NODE_ID:        node_id_in      = csr_chan.data;
            CSR_FORWARD_ENABLE: fwd_en_in       = csr_chan.data[0];
            CSR_VALID_CODE:     valid_code_in   = csr_chan.data;
            CSR_INVALID_CODE:   invalid_code_in = csr_chan.data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               prev_in = req_chan.rx_byte;
               if (store) begin
                  cap_wr_en = 1'b1;
                  fill_in   = count_inc;
               end else begin
                  fill_in   = count_base;
               end
            end
         end
         ST_CHECK_HEAD: begin
            cap_rd_en   = 1'b1;
            cap_rd_addr = CHECK_HEAD_POS;
         end
         ST_CHECK_TAG: begin
            head_ok_in  = (cap_rd_data == SYNC_SECOND);
            cap_rd_en   = 1'b1;
            cap_rd_addr = CHECK_TAG_POS;
         end
         ST_CHECK_EVAL: begin
            ok_in  = head_ok_ff && (cap_rd_data == FRAME_TAG);
            idx_in = '0;
         end
         ST_FETCH: begin
            if (in_payload) begin
               cap_rd_en   = 1'b1;
               cap_rd_addr = payload_addr(pay_idx);
               held_rd_en  = 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = in_payload ? pay_byte : hdr_byte;
               rsp_end_in   = (idx_ff == IDX_W'(FRAME_LEN - 1));
               idx_in       = idx_ff + IDX_W'(1);
               // refresh the held payload as a valid frame goes out
               if (in_payload && ok_ff) begin
                  held_wr_en    = 1'b1;
                  held_valid_in = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         node_id_ff      <= '0;
         fwd_en_ff       <= 1'b0;
         valid_code_ff   <= CHAR_ONE;
         invalid_code_ff <= '0;
         prev_ff         <= '0;
         fill_ff         <= '0;
         ok_ff           <= 1'b0;
         held_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         node_id_ff      <= node_id_in;
         fwd_en_ff       <= fwd_en_in;
         valid_code_ff   <= valid_code_in;
         invalid_code_ff <= invalid_code_in;
         prev_ff         <= prev_in;
         fill_ff         <= fill_in;
         ok_ff           <= ok_in;
         held_valid_ff   <= held_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ok_ff  <= head_ok_in;
      idx_ff      <= idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
   end

endmodule

// ----- rtl/srp_checker.sv -----
// ---------------------------------------------------------------------------
// srp_checker
// Port-level checks of the sensor frame repacker, bound to the top level.
// ---------------------------------------------------------------------------
`include "sensor_frame_repacker_defines.svh"

module srp_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [srp_pkg::BYTE_W-1:0] rsp_tx_byte,
   input logic                 rsp_frame_end
);
   import srp_pkg::*;

   logic              rsp_stall;
   logic              rsp_last_taken;
   logic              rsp_opens;
   logic [BYTE_W:0]   rsp_word;

   assign rsp_stall      = rsp_valid && !rsp_ready;
   assign rsp_last_taken = rsp_valid && rsp_ready && rsp_frame_end;
   assign rsp_opens      = !rsp_valid || (rsp_tx_byte == CHAR_HASH);
   assign rsp_word       = {rsp_tx_byte, rsp_frame_end};

   // a stalled frame byte holds
   `SRP_ASSERT_CLK(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_word), "byte not held")

   // no new sensor byte is taken until the frame is down to its last byte
   `SRP_ASSERT_CLK(a_busy_mid, rsp_valid && !rsp_frame_end |-> !req_ready, "taken mid frame")

   // after the last byte only the opening byte of the next frame may follow at once
   `SRP_ASSERT_CLK(a_frame_restart, rsp_last_taken |=> rsp_opens, "bad frame start")

endmodule

bind sensor_frame_repacker srp_checker u_srp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_tx_byte   (rsp_chan.tx_byte),
   .rsp_frame_end (rsp_chan.frame_end)
);

// ----- verif/sensor_frame_repacker_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sensor_frame_repacker_test
// Streams sensor bytes into the repacker and predicts each 44-byte frame
// from a shadow of the capture store, the held payload and the registers.
// Frame bytes are checked in order as they leave, with random stalls on
// both channels, one long receiver hold and one sender pause.
// ---------------------------------------------------------------------------
module sensor_frame_repacker_test;
   import srp_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 20;
   localparam int LONG_HOLD     = 400;
   localparam int IDLE_PERCENT  = 28;

   typedef struct {
      logic [BYTE_W-1:0] value;
      logic              wait_drain;
   } sensor_byte_type;

   typedef struct {
      logic [BYTE_W-1:0] tx_byte;
      logic              frame_end;
   } frame_byte_type;

   logic clock = 1'b0;
   logic reset;

   srp_req_if req_if ();
   srp_rsp_if rsp_if ();
   srp_csr_if csr_if ();

   sensor_frame_repacker uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // register shadows
   logic [BYTE_W-1:0] node_id_cfg      = 8'h00;
   logic              forward_cfg      = 1'b0;
   logic [BYTE_W-1:0] valid_code_cfg   = 8'h01;
   logic [BYTE_W-1:0] invalid_code_cfg = 8'h00;

   // capture shadow
   logic [BYTE_W-1:0] last_rx_byte = 8'h00;
   int                fill_level   = 0;
   logic [BYTE_W-1:0] capture_mem [CAPTURE_DEPTH];
   logic [BYTE_W-1:0] held_bytes  [PAYLOAD_LEN];

   sensor_byte_type queued_sensor_bytes [$];
   frame_byte_type  expected_frame_bytes [$];

   int   queued_total   = 0;
   logic pause_next     = 1'b0;
   logic calm_run       = 1'b0;
   logic hold_wanted    = 1'b0;
   logic hold_done;
   int   hold_left;
   int   mismatch_count = 0;
   int   frame_byte_idx = 0;
   int   cycle_count    = 0;

   initial begin
      for (int i = 0; i < CAPTURE_DEPTH; i++) capture_mem[i] = '0;
      for (int i = 0; i < PAYLOAD_LEN; i++) held_bytes[i] = '0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch at frame byte %0d: %s", $realtime, frame_byte_idx, what);
      mismatch_count++;
   endtask

   // Apply one accepted sensor byte and queue the frame it completes, if any.
   task automatic absorb_sensor_byte(input logic [BYTE_W-1:0] rx);
      logic              stored;
      logic              frame_ok;
      int                k;
      frame_byte_type    fb;
      logic [BYTE_W-1:0] frame_bytes [FRAME_LEN];
      if (last_rx_byte == SYNC_FIRST && rx == SYNC_SECOND) fill_level = 0;
      last_rx_byte = rx;
      stored = 1'b0;
      if (fill_level < CAPTURE_DEPTH) begin
         capture_mem[fill_level] = rx;
         fill_level++;
         stored = 1'b1;
      end
      if (!stored || fill_level != TRIGGER_COUNT || !forward_cfg) return;

      frame_ok = capture_mem[int'(CHECK_HEAD_POS)] == SYNC_SECOND &&
                 capture_mem[int'(CHECK_TAG_POS)] == FRAME_TAG;
      if (frame_ok) begin
         k = 0;
         // skip the separator bytes between the runs of six
         for (int p = 6; p < TRIGGER_COUNT; p++) begin
            if (p != 12 && p != 19 && p != int'(CHECK_TAG_POS)) begin
               held_bytes[k] = capture_mem[p];
               k++;
            end
         end
      end
      frame_bytes[0] = CHAR_HASH;
      frame_bytes[1] = CHAR_ONE;
      frame_bytes[2] = CHAR_HASH;
      frame_bytes[3] = CHAR_D;
      frame_bytes[4] = frame_ok ? valid_code_cfg : invalid_code_cfg;
      frame_bytes[5] = node_id_cfg;
      for (int i = 6; i < FRAME_LEN - PAYLOAD_LEN; i++) frame_bytes[i] = '0;
      for (int i = 0; i < PAYLOAD_LEN; i++)
         frame_bytes[FRAME_LEN - PAYLOAD_LEN + i] = held_bytes[i];
      for (int i = 0; i < FRAME_LEN; i++) begin
         fb.tx_byte   = frame_bytes[i];
         fb.frame_end = (i == FRAME_LEN - 1);
         expected_frame_bytes.push_back(fb);
      end
   endtask

   // sender: present queued bytes, predict on each accepted request
   always @(posedge clock) begin : drive_sensor
      sensor_byte_type nxt;
      logic            go;
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.rx_byte <= '0;
      end else begin
         if (req_if.valid && req_if.ready) absorb_sensor_byte(req_if.rx_byte);
         if (!req_if.valid || req_if.ready) begin
            go = queued_sensor_bytes.size() != 0 &&
                 (calm_run || $urandom_range(0, 99) >= IDLE_PERCENT);
            // hold a marked byte until every frame byte in flight has left
            if (go && queued_sensor_bytes[0].wait_drain && expected_frame_bytes.size() != 0)
               go = 1'b0;
            if (go) begin
               nxt = queued_sensor_bytes.pop_front();
               req_if.valid   <= 1'b1;
               req_if.rx_byte <= nxt.value;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold, started once a frame is on its way out
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_wanted && !hold_done && rsp_if.valid) begin
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= hold_left == 0 &&
                           (calm_run || $urandom_range(0, 99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin : check_frame
      frame_byte_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_frame_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", rsp_if.tx_byte));
         end else begin
            want = expected_frame_bytes.pop_front();
            if (rsp_if.tx_byte !== want.tx_byte)
               report_mismatch($sformatf("tx_byte %02h, want %02h",
                                         rsp_if.tx_byte, want.tx_byte));
            if (rsp_if.frame_end !== want.frame_end)
               report_mismatch($sformatf("frame_end %b, want %b",
                                         rsp_if.frame_end, want.frame_end));
         end
         frame_byte_idx <= frame_byte_idx + 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic logic [BYTE_W-1:0] pick_byte();
      logic [BYTE_W-1:0] b;
      b = BYTE_W'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 12) begin
         case ($urandom_range(0, 4))
            0: b = SYNC_FIRST;
            1: b = SYNC_SECOND;
            2: b = FRAME_TAG;
            3: b = 8'h00;
            default: b = 8'hFF;
         endcase
      end
      return b;
   endfunction

   task automatic add_item(input logic [BYTE_W-1:0] b);
      sensor_byte_type item;
      item.value      = b;
      item.wait_drain = pause_next;
      pause_next      = 1'b0;
      queued_sensor_bytes.push_back(item);
      queued_total++;
   endtask

   // one capture up to the trigger position, then some trailing bytes
   task automatic queue_capture(input logic with_sync, input logic tag_good, input int tail_len);
      logic [BYTE_W-1:0] b;
      if (with_sync) begin
         add_item(SYNC_FIRST);
         add_item(SYNC_SECOND);
      end
      for (int pos = with_sync ? 1 : 0; pos < TRIGGER_COUNT; pos++) begin
         b = pick_byte();
         if (pos == int'(CHECK_TAG_POS)) b = tag_good ? FRAME_TAG : (b == FRAME_TAG ? ~b : b);
         if (pos == 0 && b == SYNC_SECOND) b = 8'h00;
         add_item(b);
      end
      repeat (tail_len) add_item(pick_byte());
   endtask

   task automatic add_random(input int count);
      int goal;
      int roll;
      goal = queued_total + count;
      while (queued_total < goal) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            queue_capture(1'b1, $urandom_range(0, 99) < 80, $urandom_range(0, 10));
         end else if (roll < 85) begin
            // capture cut short by the next sync
            add_item(SYNC_FIRST);
            add_item(SYNC_SECOND);
            repeat ($urandom_range(0, 40)) add_item(pick_byte());
         end else begin
            repeat ($urandom_range(1, 6)) add_item(pick_byte());
         end
      end
   endtask

   task automatic write_register(input csr_index_type which, input logic [BYTE_W-1:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= which;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (which)
         CSR_NODE_ID:        node_id_cfg      = value;
         CSR_FORWARD_ENABLE: forward_cfg      = value[0];
         CSR_VALID_CODE:     valid_code_cfg   = value;
         CSR_INVALID_CODE:   invalid_code_cfg = value;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [BYTE_W-1:0] node, input logic fwd,
                            input logic [BYTE_W-1:0] good, input logic [BYTE_W-1:0] bad);
      write_register(CSR_NODE_ID, node);
      write_register(CSR_FORWARD_ENABLE, {7'b0, fwd});
      write_register(CSR_VALID_CODE, good);
      write_register(CSR_INVALID_CODE, bad);
   endtask

   // wait until every request is taken and every frame byte has left
   task automatic settle();
      do @(posedge clock);
      while (queued_sensor_bytes.size() != 0 || req_if.valid ||
             expected_frame_bytes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.rx_byte = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.index   = CSR_NODE_ID;
      csr_if.data    = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_all(8'hFF, 1'b1, 8'hFF, 8'h00);
      // hold the receiver off on the first frame while bytes keep coming
      hold_wanted = 1'b1;
      // capture from reset with a bad head: invalid frame with a zero payload
      queue_capture(1'b0, 1'b1, 12);
      // sync split by another byte does not restart; store stays full
      add_item(SYNC_FIRST);
      add_item(8'h00);
      add_item(SYNC_SECOND);
      add_item(8'hFF);
      queue_capture(1'b1, 1'b0, 0);
      // pause the sender until the frame above has drained
      pause_next = 1'b1;
      queue_capture(1'b1, 1'b1, 3);
      queue_capture(1'b1, 1'b0, 0);
      settle();

      // forwarding off: capture only
      write_register(CSR_FORWARD_ENABLE, 8'h00);
      queue_capture(1'b1, 1'b1, 2);
      settle();

      write_all(8'h00, 1'b1, 8'h00, 8'hFF);
      calm_run = 1'b1;
      add_random(40);
      settle();
      calm_run = 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         write_all(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 99) < 85,
                   BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
         add_random(15);
         settle();
      end

      if (expected_frame_bytes.size() != 0)
         report_mismatch($sformatf("%0d frame bytes never sent", expected_frame_bytes.size()));
      if (mismatch_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

endmodule
